[design/dra_pkg.sv]
// Shared types, sizes and codes of the descriptor range allocator.
package dra_pkg;

    // Sizes
    localparam int NUM_POOLS  = 3;
    localparam int FREE_SLOTS = 64;
    localparam int CFG_POOLS  = 3;
    localparam int POOL_IW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int IDX_W      = $clog2(FREE_SLOTS);
    localparam int CNT_W      = $clog2(FREE_SLOTS + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAP0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STR0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STR1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STR2 = 3'd5;

    // Register reset values
    localparam logic [15:0] CAP0_RST   = 16'd20000;
    localparam logic [15:0] CAP1_RST   = 16'd1024;
    localparam logic [15:0] CAP2_RST   = 16'd300;
    localparam logic [8:0]  STRIDE_RST = 9'd32;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED  = 3'd0,
        ST_FRESH   = 3'd1,
        ST_FREED   = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_FULL    = 3'd4,
        ST_BAD     = 3'd5
    } t_status;

    typedef struct packed {
        logic        command;
        logic [1:0]  pool;
        logic [15:0] count;
        logic [15:0] free_base;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] base_index;
        logic [23:0] byte_offset;
        logic [15:0] range_count;
    } t_out_item;

    // Search token that travels along the cell chain
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [15:0]      hit_base;
        logic [15:0]      last_base;
        logic [15:0]      last_cnt;
    } t_tok;

    // Query broadcast to every cell while a search runs
    typedef struct packed {
        logic [1:0]       pool;
        logic [15:0]      count;
        logic [CNT_W-1:0] n;
    } t_query;

    // Entry write broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [1:0]       pool;
        logic [IDX_W-1:0] idx;
        logic [15:0]      base;
        logic [15:0]      count;
    } t_wr;

endpackage

[design/dra_cell.sv]
// One free-list slot of every pool, with one stage of the search chain.
module dra_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [dra_pkg::IDX_W-1:0] i_idx,
    input  dra_pkg::t_query           i_query,
    input  dra_pkg::t_wr              i_wr,
    input  dra_pkg::t_tok             i_tok,
    output dra_pkg::t_tok             o_tok
);
    import dra_pkg::*;

    logic [15:0] r_base [NUM_POOLS];
    logic [15:0] r_cnt  [NUM_POOLS];
    t_tok        r_tok;
    t_tok        n_tok;
    logic [15:0] sel_base;
    logic [15:0] sel_cnt;
    logic        in_list;
    logic        is_last;

    // Look at this slot's entry of the addressed pool
    always_comb begin
        sel_base = r_base[i_query.pool[POOL_IW-1:0]];
        sel_cnt  = r_cnt[i_query.pool[POOL_IW-1:0]];
        in_list  = CNT_W'(i_idx) < i_query.n;
        is_last  = (CNT_W'(i_idx) + CNT_W'(1)) == i_query.n;
        n_tok    = i_tok;
        if (i_tok.valid && !i_tok.hit && in_list && sel_cnt == i_query.count) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_idx  = i_idx;
            n_tok.hit_base = sel_base;
        end
        if (is_last) begin
            n_tok.last_base = sel_base;
            n_tok.last_cnt  = sel_cnt;
        end
    end

    // Hand the token on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.hit       <= n_tok.hit;
        r_tok.hit_idx   <= n_tok.hit_idx;
        r_tok.hit_base  <= n_tok.hit_base;
        r_tok.last_base <= n_tok.last_base;
        r_tok.last_cnt  <= n_tok.last_cnt;
    end

    // Store an entry written to this slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == i_idx) begin
            r_base[i_wr.pool[POOL_IW-1:0]] <= i_wr.base;
            r_cnt[i_wr.pool[POOL_IW-1:0]]  <= i_wr.count;
        end
    end

    assign o_tok = r_tok;

endmodule

[design/descriptor_range_allocator_core.sv]
// Top level: request control, pool registers and the free-list cell chain.
//
//  Channel   Handshake                 Payload
//  request   start, busy               i_item   (t_in_item)
//  result    o_valid (one cycle)       o_result (t_out_item)
//  config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item at a time. An allocate sends a token down the chain of FREE_SLOTS
// cells, one cell a cycle, then S_MUL registers the result; a free or a
// rejected request goes from accept straight to S_MUL.
// Reset is synchronous and clears all bump pointers and list counts; list
// entries are only read below the count, so they need no clearing.
// The result strobe lasts one cycle and is never held off.
module descriptor_range_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  dra_pkg::t_in_item              i_item,
    output logic                           o_valid,
    output dra_pkg::t_out_item             o_result,
    input  logic                           i_cfg_we,
    input  logic [dra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dra_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dra_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL
    } t_state;

    t_state           r_state;
    logic [15:0]      r_cap    [CFG_POOLS];
    logic [8:0]       r_str    [CFG_POOLS];
    logic [15:0]      r_next   [NUM_POOLS];
    logic [CNT_W-1:0] r_nfe    [NUM_POOLS];
    logic             r_inject;
    t_query           r_query;
    t_status          r_status;
    logic [15:0]      r_base;
    logic [8:0]       r_stride;
    logic [15:0]      r_rcnt;
    logic             r_valid;
    t_out_item        r_result;

    t_tok             tok [FREE_SLOTS+1];
    t_wr              wr;
    t_tok             tok_end;
    logic             accept;
    logic             bad_req;
    logic [POOL_IW-1:0] in_p;
    logic [POOL_IW-1:0] q_p;
    logic             list_full;
    logic [16:0]      fresh_end;
    logic             no_space;
    logic [24:0]      product;

    // Decode the request and the end of the search
    always_comb begin
        accept    = start && (r_state == S_IDLE);
        in_p      = i_item.pool[POOL_IW-1:0];
        q_p       = r_query.pool[POOL_IW-1:0];
        bad_req   = (int'(i_item.pool) >= NUM_POOLS) || (int'(i_item.pool) >= CFG_POOLS)
                    || (i_item.count == 16'd0);
        list_full = !bad_req && (r_nfe[in_p] == CNT_W'(FREE_SLOTS));
        tok_end   = tok[FREE_SLOTS];
        fresh_end = {1'b0, r_next[q_p]} + {1'b0, r_query.count};
        no_space  = fresh_end > {1'b0, r_cap[q_p]};
        product   = {9'd0, r_base} * {16'd0, r_stride};
    end

    // Drive entry writes: a free pushes at the list end, a reuse fills the gap
    always_comb begin
        wr = '0;
        if (accept && !bad_req && i_item.command == CMD_FREE && !list_full) begin
            wr.en    = 1'b1;
            wr.pool  = i_item.pool;
            wr.idx   = r_nfe[in_p][IDX_W-1:0];
            wr.base  = i_item.free_base;
            wr.count = i_item.count;
        end else if (r_state == S_SCAN && tok_end.valid && tok_end.hit) begin
            wr.en    = 1'b1;
            wr.pool  = r_query.pool;
            wr.idx   = tok_end.hit_idx;
            wr.base  = tok_end.last_base;
            wr.count = tok_end.last_cnt;
        end
    end

    // Inject the search token in the cycle after accept
    assign tok[0] = {r_inject, {($bits(t_tok)-1){1'b0}}};

    // Build the chain of cells
    for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
        dra_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_query (r_query),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    // Hold the pool registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap[0] <= CAP0_RST;
            r_cap[1] <= CAP1_RST;
            r_cap[2] <= CAP2_RST;
            for (int k = 0; k < CFG_POOLS; k++) begin
                r_str[k] <= STRIDE_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAP0: r_cap[0] <= i_cfg_data;
                REG_CAP1: r_cap[1] <= i_cfg_data;
                REG_CAP2: r_cap[2] <= i_cfg_data;
                REG_STR0: r_str[0] <= i_cfg_data[8:0];
                REG_STR1: r_str[1] <= i_cfg_data[8:0];
                REG_STR2: r_str[2] <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Sequence one item: decide, update pool state, register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inject <= 1'b0;
            r_valid  <= 1'b0;
            for (int k = 0; k < NUM_POOLS; k++) begin
                r_next[k] <= 16'd0;
                r_nfe[k]  <= '0;
            end
        end else begin
            r_inject <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_query.pool  <= i_item.pool;
                        r_query.count <= i_item.count;
                        r_query.n     <= bad_req ? '0 : r_nfe[in_p];
                        if (bad_req) begin
                            r_status <= ST_BAD;
                            r_base   <= 16'd0;
                            r_stride <= 9'd0;
                            r_rcnt   <= 16'd0;
                            r_state  <= S_MUL;
                        end else if (i_item.command == CMD_FREE) begin
                            if (list_full) begin
                                r_status <= ST_FULL;
                                r_base   <= 16'd0;
                                r_stride <= 9'd0;
                                r_rcnt   <= 16'd0;
                            end else begin
                                r_nfe[in_p] <= r_nfe[in_p] + CNT_W'(1);
                                r_status    <= ST_FREED;
                                r_base      <= i_item.free_base;
                                r_stride    <= r_str[i_item.pool];
                                r_rcnt      <= i_item.count;
                            end
                            r_state <= S_MUL;
                        end else begin
                            r_inject <= 1'b1;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (tok_end.valid) begin
                        if (tok_end.hit) begin
                            r_nfe[q_p] <= r_nfe[q_p] - CNT_W'(1);
                            r_status   <= ST_REUSED;
                            r_base     <= tok_end.hit_base;
                            r_stride   <= r_str[r_query.pool];
                            r_rcnt     <= r_query.count;
                        end else if (no_space) begin
                            r_status <= ST_NOSPACE;
                            r_base   <= 16'd0;
                            r_stride <= 9'd0;
                            r_rcnt   <= 16'd0;
                        end else begin
                            r_next[q_p] <= fresh_end[15:0];
                            r_status    <= ST_FRESH;
                            r_base      <= r_next[q_p];
                            r_stride    <= r_str[r_query.pool];
                            r_rcnt      <= r_query.count;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Register the result fields with the byte offset
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_result.status      <= r_status;
            r_result.base_index  <= r_base;
            r_result.byte_offset <= product[23:0];
            r_result.range_count <= r_rcnt;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the descriptor range allocator core.
module tb_top;
    import dra_pkg::*;

    typedef struct {
        logic [15:0] base;
        logic [15:0] count;
    } t_span;

    // Track pool state, predict each grant and check results in order
    class range_scoreboard;
        logic [15:0] cap [CFG_POOLS];
        logic [8:0]  stride [CFG_POOLS];
        logic [15:0] bump [NUM_POOLS];
        logic [15:0] held_base [NUM_POOLS][FREE_SLOTS];
        logic [15:0] held_count [NUM_POOLS][FREE_SLOTS];
        int          held_len [NUM_POOLS];
        t_span       live_spans [NUM_POOLS][$];
        t_out_item   pending_grants [$];
        int          errors;
        int          shown;

        function new();
            cap[0] = CAP0_RST;
            cap[1] = CAP1_RST;
            cap[2] = CAP2_RST;
            for (int i = 0; i < CFG_POOLS; i++) stride[i] = STRIDE_RST;
            for (int i = 0; i < NUM_POOLS; i++) begin
                bump[i]     = '0;
                held_len[i] = 0;
            end
            errors = 0;
            shown  = 0;
        endfunction

        // Mirror one register write; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CAP0: cap[0] = data;
                REG_CAP1: cap[1] = data;
                REG_CAP2: cap[2] = data;
                REG_STR0: stride[0] = data[8:0];
                REG_STR1: stride[1] = data[8:0];
                REG_STR2: stride[2] = data[8:0];
                default: ;
            endcase
        endfunction

        function t_out_item make_grant(t_status st, logic [15:0] base, logic [8:0] str,
                                       logic [15:0] cnt);
            t_out_item   res;
            logic [24:0] prod;
            prod            = base * str;
            res.status      = st;
            res.base_index  = base;
            res.byte_offset = prod[23:0];
            res.range_count = cnt;
            return res;
        endfunction

        // Remember a granted range so later frees can hand it back
        function void keep_span(int p, logic [15:0] base, logic [15:0] cnt);
            t_span s;
            s.base  = base;
            s.count = cnt;
            if (live_spans[p].size() >= 64) void'(live_spans[p].pop_front());
            live_spans[p] = {live_spans[p], s};
        endfunction

        function bit take_span(int p, output logic [15:0] base, output logic [15:0] cnt);
            t_span s;
            int    k;
            if (live_spans[p].size() == 0) return 1'b0;
            k = $urandom_range(0, live_spans[p].size() - 1);
            s = live_spans[p][k];
            live_spans[p].delete(k);
            base = s.base;
            cnt  = s.count;
            return 1'b1;
        endfunction

        // Work out the grant of one request and advance the pool state
        function t_out_item predict_grant(t_in_item it);
            t_out_item   res;
            int          p;
            int          n;
            logic [16:0] reach;
            logic [15:0] base;
            res        = '0;
            res.status = ST_BAD;
            p          = it.pool;
            if (p >= NUM_POOLS || p >= CFG_POOLS || it.count == 16'd0) return res;
            n = held_len[p];
            if (it.command == CMD_FREE) begin
                if (n >= FREE_SLOTS) begin
                    res.status = ST_FULL;
                    return res;
                end
                held_base[p][n]  = it.free_base;
                held_count[p][n] = it.count;
                held_len[p]      = n + 1;
                return make_grant(ST_FREED, it.free_base, stride[p], it.count);
            end
            // Scan lowest entry first; on a hit move the last entry into the hole
            for (int i = 0; i < n; i++) begin
                if (held_count[p][i] == it.count) begin
                    base             = held_base[p][i];
                    held_base[p][i]  = held_base[p][n-1];
                    held_count[p][i] = held_count[p][n-1];
                    held_len[p]      = n - 1;
                    keep_span(p, base, it.count);
                    return make_grant(ST_REUSED, base, stride[p], it.count);
                end
            end
            reach = {1'b0, bump[p]} + {1'b0, it.count};
            if (reach > {1'b0, cap[p]}) begin
                res.status = ST_NOSPACE;
                return res;
            end
            base    = bump[p];
            bump[p] = reach[15:0];
            keep_span(p, base, it.count);
            return make_grant(ST_FRESH, base, stride[p], it.count);
        endfunction

        function void note_request(t_in_item it);
            t_out_item want;
            want           = predict_grant(it);
            pending_grants = {pending_grants, want};
        endfunction

        function void check_grant(t_out_item got);
            t_out_item want;
            if (pending_grants.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result: status %0d base %0d offset %0d count %0d",
                             got.status, got.base_index, got.byte_offset, got.range_count);
                end
                return;
            end
            want = pending_grants.pop_front();
            if (got.status !== want.status || got.base_index !== want.base_index ||
                got.byte_offset !== want.byte_offset ||
                got.range_count !== want.range_count) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("result differs: expected status %0d base %0d offset %0d count %0d",
                             want.status, want.base_index, want.byte_offset, want.range_count);
                    $display("                actual   status %0d base %0d offset %0d count %0d",
                             got.status, got.base_index, got.byte_offset, got.range_count);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = FREE_SLOTS + 16;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              i_item = '0;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    range_scoreboard ledger;
    int              cycle_count;

    descriptor_range_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Check every result in the cycle of its strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) ledger.check_grant(o_result);
    end

    // Stop a run that hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("descriptor_range_allocator_core: mismatch");
        $finish;
    end

    function automatic t_in_item make_item(logic cmd, int p, int cnt, int base);
        t_in_item it;
        it.command   = cmd;
        it.pool      = 2'(p);
        it.count     = 16'(cnt);
        it.free_base = 16'(base);
        return it;
    endfunction

    // Offer one item, optionally after a random gap, and hold it until taken
    task automatic send_item(t_in_item it, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        ledger.note_request(it);
    endtask

    // Hold off until every expected result has come back
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending_grants.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        ledger.write_reg(idx, data);
    endtask

    task automatic apply_setting(int c0, int c1, int c2, int s0, int s1, int s2);
        drain();
        cfg_write(REG_CAP0, 16'(c0));
        cfg_write(REG_CAP1, 16'(c1));
        cfg_write(REG_CAP2, 16'(c2));
        cfg_write(REG_STR0, 16'(s0));
        cfg_write(REG_STR1, 16'(s1));
        cfg_write(REG_STR2, 16'(s2));
        cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE6 : REG_SPARE7,
                  16'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
    endtask

    // Small allocations and frees of earlier grants keep the lists busy
    function automatic t_in_item churn_item();
        int          p;
        logic [15:0] b;
        logic [15:0] c;
        p = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 55) begin
            c = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 8));
            return make_item(CMD_ALLOC, p, c, $urandom_range(0, 65535));
        end
        if (p < CFG_POOLS && $urandom_range(0, 3) != 0 && ledger.take_span(p, b, c))
            return make_item(CMD_FREE, p, b == 16'd0 && c == 16'd0 ? 1 : c, b);
        return make_item(CMD_FREE, p, $urandom_range(1, 8), $urandom_range(0, 65535));
    endfunction

    // Any field values at all, zero counts included
    function automatic t_in_item noise_item();
        int c;
        c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535);
        return make_item($urandom_range(0, 1), $urandom_range(0, 3), c,
                         $urandom_range(0, 65535));
    endfunction

    task automatic run_random(int n_items, bit calm);
        int       done;
        int       kind;
        int       seg;
        int       p;
        int       extra;
        int       cnt;
        bit       gaps;
        t_in_item it;
        done = 0;
        while (done < n_items) begin
            kind = $urandom_range(0, 99);
            seg  = $urandom_range(6, 40);
            gaps = !calm && ($urandom_range(0, 3) != 0);
            if (kind < 10) begin
                // Fill one free list and push past the full mark
                p     = $urandom_range(0, 2);
                extra = 0;
                while (extra < 2) begin
                    if (ledger.held_len[p] >= FREE_SLOTS) extra++;
                    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                      : $urandom_range(1, 8);
                    it = make_item(CMD_FREE, p, cnt, $urandom_range(0, 65535));
                    send_item(it, gaps);
                    done++;
                end
            end else begin
                repeat (seg) begin
                    it = (kind < 75) ? churn_item() : noise_item();
                    send_item(it, gaps);
                    done++;
                end
            end
        end
    endtask

    task automatic run_directed;
        // Rejected requests: bad pool and zero count
        send_item(make_item(CMD_ALLOC, 3, 1, 0), 1'b1);
        send_item(make_item(CMD_FREE, 3, 65535, 65535), 1'b1);
        send_item(make_item(CMD_ALLOC, 0, 0, 0), 1'b0);
        send_item(make_item(CMD_FREE, 1, 0, 5), 1'b0);
        // Fresh ranges up to the exact capacity, then out of space
        send_item(make_item(CMD_ALLOC, 0, 1, 65535), 1'b0);
        send_item(make_item(CMD_ALLOC, 0, 19999, 0), 1'b1);
        send_item(make_item(CMD_ALLOC, 0, 1, 0), 1'b0);
        // Unchecked free of the widest range, then reuse it
        send_item(make_item(CMD_FREE, 0, 65535, 65535), 1'b0);
        send_item(make_item(CMD_ALLOC, 0, 65535, 0), 1'b0);
        send_item(make_item(CMD_ALLOC, 1, 1024, 0), 1'b1);
        send_item(make_item(CMD_ALLOC, 1, 65535, 0), 1'b0);
        // Exact-fit search, lowest entry first, with last-into-hole removal
        send_item(make_item(CMD_FREE, 2, 3, 10), 1'b0);
        send_item(make_item(CMD_FREE, 2, 4, 20), 1'b0);
        send_item(make_item(CMD_FREE, 2, 3, 30), 1'b1);
        send_item(make_item(CMD_FREE, 2, 5, 40), 1'b0);
        send_item(make_item(CMD_ALLOC, 2, 3, 0), 1'b0);
        send_item(make_item(CMD_ALLOC, 2, 5, 0), 1'b0);
        send_item(make_item(CMD_ALLOC, 2, 3, 0), 1'b1);
        send_item(make_item(CMD_ALLOC, 2, 4, 0), 1'b0);
        send_item(make_item(CMD_ALLOC, 2, 4, 0), 1'b0);
        send_item(make_item(CMD_ALLOC, 2, 297, 0), 1'b0);
    endtask

    initial begin
        ledger = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(250, 1'b0);
        apply_setting(65535, 0, 65535, 256, 1, 0);
        run_random(250, 1'b0);
        apply_setting(0, 65535, 2000, 511, 16'hFE01, 256);
        run_random(250, 1'b0);
        apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_random(250, 1'b0);
        apply_setting($urandom_range(1000, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 4000), $urandom_range(1, 256),
                      $urandom_range(1, 256), $urandom_range(0, 65535));
        run_random(250, 1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.pending_grants.size() != 0) begin
            ledger.errors += ledger.pending_grants.size();
            $display("%0d expected results never arrived", ledger.pending_grants.size());
        end
        if (ledger.errors == 0) begin
            $display("descriptor_range_allocator_core: match");
        end else begin
            $display("descriptor_range_allocator_core: mismatch");
        end
        $finish;
    end
endmodule

[filelist.f]
design/dra_pkg.sv
design/dra_cell.sv
design/descriptor_range_allocator_core.sv
tb/sv/tb_top.sv
